/* hdl/rgbi_pkg.sv */
// Shared types, constants and codes for the rectilinear grid bilinear interpolator.
// No dependencies.
package rgbi_pkg;
  localparam int MAX_X_POINTS_DEF = 16;
  localparam int MAX_Y_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD_X = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_Y = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_G = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_W = 2'd2;

  localparam logic [0:0] CFG_X_USED = 1'b0;
  localparam logic [0:0] CFG_Y_USED = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SRCH_X, ST_SRCH_Y, ST_FET_X0, ST_FET_X1, ST_FET_Y0, ST_FET_Y1,
    ST_CHECK, ST_DIV_X, ST_DIV_Y, ST_G00, ST_G01, ST_G10, ST_G11,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_OUT
  } state_t;

  // Multiply request to the shared multiply-accumulate unit
  typedef struct packed {
    logic              clr;
    logic              en;
    logic signed [DATA_W+1:0] a;
    logic signed [DATA_W+1:0] b;
  } mac_req_t;
endpackage

/* hdl/rgbi_if.sv */
// Valid/ready channel interfaces for input beats, result beats and config writes.
// Depends on rgbi_pkg.
interface rgbi_in_if;
  import rgbi_pkg::*;
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0] column_index;
  logic [IDX_W-1:0] row_index;
  logic signed [DATA_W-1:0] load_value;
  logic signed [DATA_W-1:0] query_x;
  logic signed [DATA_W-1:0] query_y;
  modport source (output valid, kind, column_index, row_index, load_value, query_x,
                  query_y, input ready);
  modport sink (input valid, kind, column_index, row_index, load_value, query_x,
                query_y, output ready);
endinterface

interface rgbi_out_if;
  import rgbi_pkg::*;
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] interp_value;
  logic [STAT_W-1:0] status;
  modport source (output valid, interp_value, status, input ready);
  modport sink (input valid, interp_value, status, output ready);
endinterface

interface rgbi_cfg_if;
  import rgbi_pkg::*;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/rgbi_divider.sv */
// Restoring divider, one quotient bit per cycle, for the interpolation weights.
// Depends on rgbi_pkg.
module rgbi_divider #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import rgbi_pkg::*;
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [DEN_W:0] trial;

  // one shift-subtract step per cycle
  always_comb begin
    trial = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign quot = q_nxt;
endmodule

/* hdl/rgbi_mac.sv */
// Shared signed multiply-accumulate unit used for all blend products.
// Depends on rgbi_pkg.
module rgbi_mac (
  input  logic                     clk,
  input  rgbi_pkg::mac_req_t       req,
  output logic signed [2*rgbi_pkg::DATA_W+5:0] acc
);
  import rgbi_pkg::*;
  localparam int AW = 2*DATA_W + 6;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [2*DATA_W+3:0] prod;

  // 34x34 product accumulated into a wide register; clr with en starts a new sum
  always_comb begin
    prod = req.a * req.b;
    acc_nxt = acc_r;
    if (req.clr) acc_nxt = req.en ? AW'(prod) : '0;
    else if (req.en) acc_nxt = acc_r + AW'(prod);
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

/* hdl/rectilinear_grid_bilinear_interp_unit.sv */
// Top level of the rectilinear grid bilinear interpolator: stores, sequencer, output.
// Depends on rgbi_pkg, rgbi_if, rgbi_divider and rgbi_mac.
//
// Load beats (axis entry or grid sample) are written to the stores when accepted. A
// query runs two lower-bound searches (each probe waits for the registered read of
// the axis store), four axis fetches and a check, two weight divisions on the
// one-bit-per-cycle divider (x then y), four grid reads and six passes through the
// single shared multiply-accumulator before the result register is loaded; the
// sequencer then returns to idle before the next beat is taken. Points outside the
// grid skip everything after the search. The finished result waits in the output
// register while the next beat is taken; if a further result is ready before that
// one is taken, the sequencer holds in its last state.
module rectilinear_grid_bilinear_interp_unit
  import rgbi_pkg::*;
#(
  parameter int MAX_X_POINTS = MAX_X_POINTS_DEF,
  parameter int MAX_Y_POINTS = MAX_Y_POINTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  rgbi_in_if.sink in_ch,
  rgbi_out_if.source out_ch,
  rgbi_cfg_if.sink cfg_ch
);
  localparam int XW = $clog2(MAX_X_POINTS);
  localparam int YW = $clog2(MAX_Y_POINTS);
  localparam int KW = (XW > YW ? XW : YW) + 1;
  localparam int NUM_W = DATA_W + 1 + FRAC_BITS;
  localparam int DEN_W = DATA_W + 1;
  localparam int WW = FRAC_BITS + 1;
  localparam int AW = 2*DATA_W + 6;
  localparam logic [KW-1:0] MAXX_K = KW'(MAX_X_POINTS);
  localparam logic [KW-1:0] MAXY_K = KW'(MAX_Y_POINTS);

  // stores
  logic signed [DATA_W-1:0] xs_mem [MAX_X_POINTS];
  logic signed [DATA_W-1:0] ys_mem [MAX_Y_POINTS];
  logic signed [DATA_W-1:0] g_mem [MAX_X_POINTS*MAX_Y_POINTS];
  logic signed [DATA_W-1:0] xs_rd_r, ys_rd_r, g_rd_r;

  logic [CNT_W-1:0] xused_r, yused_r;
  state_t st_r, st_nxt;
  logic signed [DATA_W-1:0] qx_r, qy_r;
  logic [KW-1:0] first_r, first_nxt, count_r, count_nxt;
  logic [KW-1:0] kx_r, ky_r, nx, ny;
  logic signed [DATA_W-1:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [DATA_W-1:0] g00_r, g01_r, g10_r, g11_r;
  logic [WW-1:0] ax_r, ay_r;
  logic signed [DATA_W+1:0] f1_r, f2_r;
  logic [STAT_W-1:0] stat_r;
  logic out_v_r;
  logic signed [DATA_W-1:0] out_val_r;
  logic [STAT_W-1:0] out_st_r;

  logic [KW-1:0] step, it;
  logic [XW-1:0] xa;
  logic [YW-1:0] ya;
  logic [XW+YW-1:0] ga;
  logic signed [DATA_W-1:0] xa_q;
  logic lt;
  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, quot;
  logic [DEN_W-1:0] div_den;
  logic signed [DATA_W:0] num_d, den_d;
  logic [WW-1:0] wcalc;
  mac_req_t mreq;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rnd, flo;
  logic signed [DATA_W+1:0] blend_v;
  logic in_acc;
  logic out_load;

  // effective used lengths
  always_comb begin
    if (xused_r < CNT_W'(2)) nx = KW'(2);
    else if (KW'(xused_r) > MAXX_K) nx = MAXX_K;
    else nx = KW'(xused_r);
    if (yused_r < CNT_W'(2)) ny = KW'(2);
    else if (KW'(yused_r) > MAXY_K) ny = MAXY_K;
    else ny = KW'(yused_r);
  end

  assign in_ch.ready = (st_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc = in_ch.valid && in_ch.ready;
  // result register takes a new beat once the previous one is gone or leaving
  assign out_load = (st_r == ST_OUT) && (!out_v_r || out_ch.ready);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xused_r <= CNT_W'(16);
      yused_r <= CNT_W'(16);
    end else if (cfg_ch.valid && cfg_ch.index[7:1] == '0) begin
      if (cfg_ch.index[0] == CFG_X_USED) xused_r <= cfg_ch.data[CNT_W-1:0];
      else if (cfg_ch.index[0] == CFG_Y_USED) yused_r <= cfg_ch.data[CNT_W-1:0];
    end
  end

  // search step and store addresses
  always_comb begin
    step = count_r >> 1;
    it = first_r + step;
    xa = '0;
    ya = '0;
    ga = '0;
    case (st_r)
      ST_SRCH_X: xa = it[XW-1:0];
      ST_SRCH_Y: ya = it[YW-1:0];
      ST_FET_X0: xa = XW'(kx_r - 1'b1);
      ST_FET_X1: xa = kx_r[XW-1:0];
      ST_FET_Y0: ya = YW'(ky_r - 1'b1);
      ST_FET_Y1: ya = ky_r[YW-1:0];
      ST_G00: ga = {YW'(ky_r - 1'b1), XW'(kx_r - 1'b1)};
      ST_G01: ga = {YW'(ky_r - 1'b1), kx_r[XW-1:0]};
      ST_G10: ga = {ky_r[YW-1:0], XW'(kx_r - 1'b1)};
      ST_G11: ga = {ky_r[YW-1:0], kx_r[XW-1:0]};
      default: ;
    endcase
  end

  // memories: synchronous read, one write port
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.kind == KIND_LOAD_X && 32'(in_ch.column_index) < MAX_X_POINTS)
      xs_mem[XW'(in_ch.column_index)] <= in_ch.load_value;
    if (in_acc && in_ch.kind == KIND_LOAD_Y && 32'(in_ch.row_index) < MAX_Y_POINTS)
      ys_mem[YW'(in_ch.row_index)] <= in_ch.load_value;
    if (in_acc && in_ch.kind == KIND_LOAD_G && 32'(in_ch.column_index) < MAX_X_POINTS
        && 32'(in_ch.row_index) < MAX_Y_POINTS)
      g_mem[{YW'(in_ch.row_index), XW'(in_ch.column_index)}] <= in_ch.load_value;
    xs_rd_r <= xs_mem[xa];
    ys_rd_r <= ys_mem[ya];
    g_rd_r <= g_mem[ga];
  end

  // search compare is done on data read last cycle; so each search step has a read phase and a compare phase
  logic ph_r;
  assign xa_q = (st_r == ST_SRCH_X) ? qx_r : qy_r;
  assign lt = ((st_r == ST_SRCH_X) ? xs_rd_r : ys_rd_r) < xa_q;

  // weight divider operands
  always_comb begin
    if (st_r == ST_DIV_X) begin
      num_d = $signed({qx_r[DATA_W-1], qx_r}) - $signed({x0_r[DATA_W-1], x0_r});
      den_d = $signed({x1_r[DATA_W-1], x1_r}) - $signed({x0_r[DATA_W-1], x0_r});
    end else begin
      num_d = $signed({qy_r[DATA_W-1], qy_r}) - $signed({y0_r[DATA_W-1], y0_r});
      den_d = $signed({y1_r[DATA_W-1], y1_r}) - $signed({y0_r[DATA_W-1], y0_r});
    end
    div_num = {num_d[DATA_W:0], FRAC_BITS'(0)};
    div_den = den_d;
    if (num_d <= 0) wcalc = '0;
    else if (num_d >= den_d) wcalc = WW'(1) << FRAC_BITS;
    else wcalc = quot[WW-1:0];
  end

  logic dstart_r;
  assign div_start = dstart_r;

  rgbi_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  // MAC operand selection per blend pass; each blend starts a fresh sum
  always_comb begin
    mreq.clr = 1'b0;
    mreq.en = 1'b1;
    mreq.a = '0;
    mreq.b = '0;
    case (st_r)
      ST_M0: begin
        mreq.clr = 1'b1;
        mreq.a = (DATA_W+2)'((WW+1)'(1) << FRAC_BITS) - (DATA_W+2)'(ax_r);
        mreq.b = (DATA_W+2)'(g00_r);
      end
      ST_M1: begin
        mreq.a = (DATA_W+2)'(ax_r);
        mreq.b = (DATA_W+2)'(g01_r);
      end
      ST_M2: begin
        mreq.clr = 1'b1;
        mreq.a = (DATA_W+2)'((WW+1)'(1) << FRAC_BITS) - (DATA_W+2)'(ax_r);
        mreq.b = (DATA_W+2)'(g10_r);
      end
      ST_M3: begin
        mreq.a = (DATA_W+2)'(ax_r);
        mreq.b = (DATA_W+2)'(g11_r);
      end
      ST_M4: begin
        mreq.clr = 1'b1;
        mreq.a = (DATA_W+2)'((WW+1)'(1) << FRAC_BITS) - (DATA_W+2)'(ay_r);
        mreq.b = f1_r;
      end
      ST_M5: begin
        mreq.a = (DATA_W+2)'(ay_r);
        mreq.b = f2_r;
      end
      ST_OUT: begin
        // hold the final sum while the result waits
        mreq.en = 1'b0;
      end
      default: begin
        mreq.clr = 1'b1;
        mreq.en = 1'b0;
      end
    endcase
  end

  rgbi_mac u_mac (.clk(clk), .req(mreq), .acc(acc));

  // round half up, floor shift
  assign rnd = acc + (AW'(1) <<< (FRAC_BITS - 1));
  assign flo = rnd >>> FRAC_BITS;
  assign blend_v = flo[DATA_W+1:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_acc && in_ch.kind == KIND_QUERY) st_nxt = ST_SRCH_X;
      ST_SRCH_X: if (ph_r && count_r == '0) st_nxt = ST_SRCH_Y;
                 else if (!ph_r && count_r == '0) st_nxt = ST_SRCH_Y;
      ST_SRCH_Y: if (count_r == '0) begin
                   if (kx_r == '0 || kx_r >= nx || first_r == '0 || first_r >= ny)
                     st_nxt = ST_OUT;
                   else st_nxt = ST_FET_X0;
                 end
      ST_FET_X0: st_nxt = ST_FET_X1;
      ST_FET_X1: st_nxt = ST_FET_Y0;
      ST_FET_Y0: st_nxt = ST_FET_Y1;
      ST_FET_Y1: st_nxt = ST_CHECK;
      ST_CHECK: if (x1_r <= x0_r || ys_rd_r <= y0_r) st_nxt = ST_OUT;
                else st_nxt = ST_DIV_X;
      ST_DIV_X: if (div_done) st_nxt = ST_DIV_Y;
      ST_DIV_Y: if (div_done) st_nxt = ST_G00;
      ST_G00: st_nxt = ST_G01;
      ST_G01: st_nxt = ST_G10;
      ST_G10: st_nxt = ST_G11;
      ST_G11: st_nxt = ST_M0;
      ST_M0: st_nxt = ST_M1;
      ST_M1: st_nxt = ST_M2;
      ST_M2: st_nxt = ST_M3;
      ST_M3: st_nxt = ST_M4;
      ST_M4: st_nxt = ST_M5;
      ST_M5: st_nxt = ST_OUT;
      ST_OUT: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // search bookkeeping
  always_comb begin
    first_nxt = first_r;
    count_nxt = count_r;
    if (st_r == ST_IDLE) begin
      first_nxt = '0;
      count_nxt = nx;
    end else if ((st_r == ST_SRCH_X || st_r == ST_SRCH_Y) && ph_r) begin
      if (lt) begin
        first_nxt = it + 1'b1;
        count_nxt = count_r - step - 1'b1;
      end else count_nxt = step;
    end else if (st_r == ST_SRCH_X && count_r == '0) begin
      first_nxt = '0;
      count_nxt = ny;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_v_r <= 1'b0;
      ph_r <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      dstart_r <= (st_r == ST_CHECK && st_nxt == ST_DIV_X) ||
                  (st_r == ST_DIV_X && div_done);
      if (st_r == ST_SRCH_X || st_r == ST_SRCH_Y) ph_r <= (count_r != '0) && !ph_r;
      else ph_r <= 1'b0;
      if (out_load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    count_r <= count_nxt;
    if (in_acc) begin
      qx_r <= in_ch.query_x;
      qy_r <= in_ch.query_y;
      stat_r <= STAT_OK;
    end
    if (st_r == ST_SRCH_X && count_r == '0) kx_r <= first_r;
    if (st_r == ST_SRCH_Y && count_r == '0) begin
      ky_r <= first_r;
      if (kx_r == '0 || kx_r >= nx || first_r == '0 || first_r >= ny) stat_r <= STAT_OUTSIDE;
    end
    if (st_r == ST_FET_X1) x0_r <= xs_rd_r;
    if (st_r == ST_FET_Y0) x1_r <= xs_rd_r;
    if (st_r == ST_FET_Y1) y0_r <= ys_rd_r;
    if (st_r == ST_CHECK) begin
      y1_r <= ys_rd_r;
      if (x1_r <= x0_r || ys_rd_r <= y0_r) stat_r <= STAT_ZERO_W;
    end
    if (st_r == ST_DIV_X && div_done) ax_r <= wcalc;
    if (st_r == ST_DIV_Y && div_done) ay_r <= wcalc;
    if (st_r == ST_G01) g00_r <= g_rd_r;
    if (st_r == ST_G10) g01_r <= g_rd_r;
    if (st_r == ST_G11) g10_r <= g_rd_r;
    if (st_r == ST_M0) g11_r <= g_rd_r;
    if (st_r == ST_M2) f1_r <= blend_v;
    if (st_r == ST_M4) f2_r <= blend_v;
    if (out_load) begin
      out_st_r <= stat_r;
      if (stat_r != STAT_OK) out_val_r <= '0;
      else if (flo > AW'(32'sh7fffffff)) out_val_r <= 32'sh7fffffff;
      else if (flo < -AW'(33'sh080000000)) out_val_r <= 32'sh80000000;
      else out_val_r <= flo[DATA_W-1:0];
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.interp_value = out_val_r;
  assign out_ch.status = out_st_r;
endmodule

/* tb/sv/rgbi_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the rectilinear grid bilinear interpolator: watches the input,
// result and config channels, predicts every query result and compares it.
// Depends on rgbi_pkg and rgbi_if.
module rgbi_checker
  import rgbi_pkg::*;
(
  input logic clk,
  input logic rst_n,
  rgbi_in_if in_ch,
  rgbi_out_if out_ch,
  rgbi_cfg_if cfg_ch,
  output int fail_count,
  output int pending_count,
  output int query_count,
  output int status_seen [3]
);
  localparam int NX = MAX_X_POINTS_DEF;
  localparam int NY = MAX_Y_POINTS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam longint HALF = longint'(1) << (FB - 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic [STAT_W-1:0] status;
  } interp_result_t;

  longint x_axis [NX];
  longint y_axis [NY];
  longint grid [NX*NY];
  logic [CNT_W-1:0] x_used, y_used;
  interp_result_t expected_q [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int clamp_len(input logic [CNT_W-1:0] r, input int maxn);
    if (r < 2) return 2;
    if (r > maxn) return maxn;
    return int'(r);
  endfunction

  // lower-bound count over the used part of an axis
  function automatic int count_below(input longint a [], input int n, input longint q);
    int first, cnt, step;
    first = 0;
    cnt = n;
    while (cnt > 0) begin
      step = cnt / 2;
      if (a[first+step] < q) begin
        first = first + step + 1;
        cnt = cnt - step - 1;
      end else begin
        cnt = step;
      end
    end
    return first;
  endfunction

  function automatic longint axis_weight(input longint q, input longint lo, input longint hi);
    longint num, den;
    num = q - lo;
    den = hi - lo;
    if (num <= 0) return 0;
    if (num >= den) return ONE;
    return (num << FB) / den;
  endfunction

  function automatic longint mix(input longint a, input longint b, input longint w);
    longint v;
    v = (ONE - w) * a + w * b + HALF;
    return v >>> FB;
  endfunction

  function automatic interp_result_t predict_point(input longint qx, input longint qy);
    interp_result_t r;
    longint xa [], ya [];
    int nx, ny, kx, ky;
    longint ax, ay, f1, f2, v;
    nx = clamp_len(x_used, NX);
    ny = clamp_len(y_used, NY);
    xa = new[NX];
    ya = new[NY];
    foreach (x_axis[i]) xa[i] = x_axis[i];
    foreach (y_axis[i]) ya[i] = y_axis[i];
    kx = count_below(xa, nx, qx);
    ky = count_below(ya, ny, qy);
    r.interp_value = '0;
    r.status = STAT_OK;
    if (kx == 0 || kx >= nx || ky == 0 || ky >= ny) begin
      r.status = STAT_OUTSIDE;
    end else if (x_axis[kx] <= x_axis[kx-1] || y_axis[ky] <= y_axis[ky-1]) begin
      r.status = STAT_ZERO_W;
    end else begin
      ax = axis_weight(qx, x_axis[kx-1], x_axis[kx]);
      ay = axis_weight(qy, y_axis[ky-1], y_axis[ky]);
      f1 = mix(grid[(ky-1)*NX+kx-1], grid[(ky-1)*NX+kx], ax);
      f2 = mix(grid[ky*NX+kx-1], grid[ky*NX+kx], ax);
      v = mix(f1, f2, ay);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      r.interp_value = v[DATA_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    interp_result_t want;
    if (!rst_n) begin
      x_used <= CNT_W'(NX);
      y_used <= CNT_W'(NY);
      expected_q.delete();
      fail_count <= 0;
      query_count <= 0;
      status_seen <= '{0, 0, 0};
      foreach (x_axis[i]) x_axis[i] = 0;
      foreach (y_axis[i]) y_axis[i] = 0;
      foreach (grid[i]) grid[i] = 0;
    end else begin
      // config beat
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == 8'(CFG_X_USED)) x_used <= cfg_ch.data[CNT_W-1:0];
        else if (cfg_ch.index == 8'(CFG_Y_USED)) y_used <= cfg_ch.data[CNT_W-1:0];
      end
      // input beat
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          KIND_LOAD_X: x_axis[in_ch.column_index] = in_ch.load_value;
          KIND_LOAD_Y: y_axis[in_ch.row_index] = in_ch.load_value;
          KIND_LOAD_G: grid[in_ch.row_index*NX + in_ch.column_index] = in_ch.load_value;
          KIND_QUERY: begin
            expected_q = {expected_q, predict_point(in_ch.query_x, in_ch.query_y)};
            query_count <= query_count + 1;
          end
          default: ;
        endcase
      end
      // result beat
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, value", out_ch.interp_value, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.status != want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.interp_value != want.interp_value)
            report_mismatch("interp_value", out_ch.interp_value, want.interp_value);
          if (out_ch.status < 3) status_seen[out_ch.status]++;
        end
      end
    end
    pending_count = expected_q.size();
  end
endmodule

/* tb/sv/tb_rectilinear_grid_bilinear_interp_unit.sv */
`timescale 1ns / 1ps
// Top of the interpolator testbench: clock, reset, stimulus and verdict.
// Depends on rgbi_pkg, rgbi_if, rgbi_checker and the block itself.
module tb_rectilinear_grid_bilinear_interp_unit;
  import rgbi_pkg::*;

  localparam int NX = MAX_X_POINTS_DEF;
  localparam int NY = MAX_Y_POINTS_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  int fail_count, pending_count, query_count;
  int status_seen [3];
  int send_idle_pct, recv_idle_pct;
  longint cycles;

  rgbi_in_if in_ch ();
  rgbi_out_if out_ch ();
  rgbi_cfg_if cfg_ch ();

  rectilinear_grid_bilinear_interp_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  rgbi_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count),
    .query_count(query_count), .status_seen(status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL rectilinear_grid_bilinear_interp_unit");
        $finish;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after the beat so back-to-back beats need no gap
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] col,
                           input logic [IDX_W-1:0] row, input logic [DATA_W-1:0] lv,
                           input logic [DATA_W-1:0] qx, input logic [DATA_W-1:0] qy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.column_index <= col;
    in_ch.row_index <= row;
    in_ch.load_value <= lv;
    in_ch.query_x <= qx;
    in_ch.query_y <= qy;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic query(input logic [DATA_W-1:0] qx, input logic [DATA_W-1:0] qy);
    send_beat(KIND_QUERY, 4'($urandom), 4'($urandom), $urandom, qx, qy);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for outstanding results, then some settling time
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // fill both axes sorted with random steps from a random start (x from the minimum when wide), and the grid
  task automatic load_tables(input bit dup, input bit wide);
    longint x, y;
    int step_max;
    step_max = wide ? 32'h0fff_ffff : 32'h0004_0000;
    x = wide ? -longint'(32'sh7fff_ffff) - 1 : longint'($signed($urandom_range(32'h40000))) - 32'h20000;
    y = x + $urandom_range(1000);
    for (int i = 0; i < NX; i++) begin
      send_beat(KIND_LOAD_X, 4'(i), 4'($urandom), x[31:0], $urandom, $urandom);
      x += (dup && $urandom_range(3) == 0) ? 0 : $urandom_range(step_max, 1);
    end
    for (int i = 0; i < NY; i++) begin
      send_beat(KIND_LOAD_Y, 4'($urandom), 4'(i), y[31:0], $urandom, $urandom);
      y += (dup && $urandom_range(3) == 0) ? 0 : $urandom_range(step_max, 1);
    end
    for (int r = 0; r < NY; r++)
      for (int c = 0; c < NX; c++)
        send_beat(KIND_LOAD_G, 4'(c), 4'(r),
                  ($urandom_range(3) == 0) ? {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)}
                                           : 32'($signed($urandom_range(32'h3fffff)) - 32'h200000),
                  $urandom, $urandom);
  endtask

  // random query: mostly near the loaded axis span, some anywhere; now and then a random beat of any kind instead
  task automatic random_queries(input int n);
    logic [DATA_W-1:0] qx, qy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) begin
        qx = $urandom_range(32'h0040_0000) - 32'h0008_0000;
        qy = $urandom_range(32'h0040_0000) - 32'h0008_0000;
      end else begin
        qx = $urandom;
        qy = $urandom;
      end
      if ($urandom_range(15) == 0) send_beat(2'($urandom), 4'($urandom), 4'($urandom),
                                              $urandom, qx, qy);
      else query(qx, qy);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 69;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD_X;
    in_ch.column_index = '0;
    in_ch.row_index = '0;
    in_ch.load_value = '0;
    in_ch.query_x = '0;
    in_ch.query_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full-range axes, corners, outside points, extremes
    load_tables(1'b0, 1'b1);
    query(32'h8000_0000, 32'h8000_0000);
    query(32'h7fff_ffff, 32'h7fff_ffff);
    query(32'h8000_0001, 32'h8000_0001);
    query(32'h0000_0000, 32'h0000_0000);
    query(32'hffff_ffff, 32'h0000_0001);
    query(32'h0123_4567, 32'h7fff_0000);
    // zero-width intervals and unsorted axis
    send_beat(KIND_LOAD_X, 4'd3, 4'd0, 32'h8000_0000, '0, '0);
    query(32'h8000_0001, 32'h0000_0000);
    query($urandom, $urandom);
    drain();

    // used-length extremes: below 2, above 16, out-of-range index
    write_reg(8'(CFG_X_USED), 32'd0);
    write_reg(8'(CFG_Y_USED), 32'hffff_ffff);
    write_reg(8'd7, 32'd3);
    load_tables(1'b1, 1'b0);
    random_queries(12);
    drain();

    // random phases, one per idle profile
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 69; recv_idle_pct = 17; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(8'(CFG_X_USED), $urandom_range(31));
      write_reg(8'(CFG_Y_USED), (ph == 0) ? 32'd16 : 32'($urandom_range(2, 16)));
      load_tables($urandom_range(3) == 0, ph == 1);
      random_queries(80);
      drain();
    end

    $display("covered %0d queries: %0d ok, %0d outside, %0d zero-width", query_count,
             status_seen[0], status_seen[1], status_seen[2]);
    if (fail_count == 0) begin
      $display("PASS rectilinear_grid_bilinear_interp_unit");
    end else begin
      $display("FAIL rectilinear_grid_bilinear_interp_unit");
    end
    $finish;
  end
endmodule
